### hdl/contrast_stretch_rgb_top_macros.svh
// Assertion macros for the contrast stretch block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef CONTRAST_STRETCH_RGB_TOP_MACROS_SVH
`define CONTRAST_STRETCH_RGB_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define CSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held
`define CSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/csr_pkg.sv
// Shared types and constants for the contrast stretch block.
// No dependencies; the other files but the macro header refer to it by scoped names.
package csr_pkg;

  localparam logic [7:0] LEVEL_TOP = 8'd255;
  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  localparam logic KIND_GATHER = 1'b0;
  localparam logic KIND_MAP    = 1'b1;

  typedef enum logic [0:0] {
    REG_OUT_LOW  = 1'b0,
    REG_OUT_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic       kind;
    logic       first_of_frame;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_pix_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [2:0] degenerate_mask;
  } out_pix_t;

  // Step controls from the sequencer to every lane
  typedef struct packed {
    logic gather;
    logic restart;
    logic capture;
    logic mul;
    logic sum;
    logic div;
  } lane_ctl_t;

endpackage

### hdl/csr_stream_if.sv
// Valid/ready stream interfaces for pixel requests and stretched results.
// Depends on csr_pkg for the payload types.
interface csr_in_if;
  logic             valid;
  logic             ready;
  csr_pkg::in_pix_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csr_out_if;
  logic              valid;
  logic              ready;
  csr_pkg::out_pix_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/csr_lane.sv
// One colour lane: min/max tracking, stretch products and a radix-2 divider.
// Depends on csr_pkg; stepped by csr_seq through a lane_ctl_t struct.
module csr_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  csr_pkg::lane_ctl_t  ctl,
  input  logic [7:0]          pix,
  input  logic [7:0]          lo,
  input  logic [7:0]          hi,
  output logic [7:0]          res,
  output logic                degen
);

  logic [7:0]         min_r, min_nxt;
  logic [7:0]         max_r, max_nxt;
  logic [7:0]         p_r;
  logic signed [17:0] prod_a_r;
  logic [15:0]        prod_b_r;
  logic [15:0]        prod_c_r;
  logic [15:0]        rem_r;
  logic [14:0]        dsh_r;
  logic [7:0]         q_r;
  logic               degen_r;
  logic               zero_r;
  logic               sat_r;

  logic [7:0]         base_min;
  logic [7:0]         base_max;
  logic signed [8:0]  span;
  logic signed [17:0] prod_a_nxt;
  logic [18:0]        num;
  logic [7:0]         den;
  logic               is_degen;
  logic               is_sat;
  logic [16:0]        trial;

  // Running statistics, restarted on the first pixel of a frame
  always_comb begin
    base_min = ctl.restart ? csr_pkg::LEVEL_TOP : min_r;
    base_max = ctl.restart ? 8'd0 : max_r;
    min_nxt  = (pix < base_min) ? pix : base_min;
    max_nxt  = (pix > base_max) ? pix : base_max;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= csr_pkg::LEVEL_TOP;
      max_r <= 8'd0;
    end else if (ctl.gather) begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  // Products of the stretch numerator
  always_comb begin
    span       = $signed({1'b0, hi}) - $signed({1'b0, lo});
    prod_a_nxt = $signed({{9{span[8]}}, span} * {10'd0, p_r});
  end

  // Numerator, divisor and the cases that bypass the divider
  always_comb begin
    num      = {prod_a_r[17], prod_a_r} + {3'b000, prod_b_r} - {3'b000, prod_c_r};
    den      = max_r - min_r;
    is_degen = (max_r <= min_r);
    is_sat   = !num[18] && (num[17:0] >= {2'b00, den, 8'h00});
    trial    = {1'b0, rem_r} - {2'b00, dsh_r};
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      p_r <= pix;
    end
    if (ctl.mul) begin
      prod_a_r <= prod_a_nxt;
      prod_b_r <= {8'd0, lo} * {8'd0, max_r};
      prod_c_r <= {8'd0, hi} * {8'd0, min_r};
    end
    if (ctl.sum) begin
      degen_r <= is_degen;
      zero_r  <= is_degen || num[18];
      sat_r   <= is_sat;
      rem_r   <= num[15:0];
      dsh_r   <= {den, 7'd0};
      q_r     <= 8'd0;
    end else if (ctl.div) begin
      // Restoring step: subtract the shifted divisor when it fits
      if (!trial[16]) begin
        rem_r <= trial[15:0];
        q_r   <= {q_r[6:0], 1'b1};
      end else begin
        q_r   <= {q_r[6:0], 1'b0};
      end
      dsh_r <= {1'b0, dsh_r[14:1]};
    end
  end

  // Clamp below zero and above full scale; a degenerate channel reads as zero
  always_comb begin
    if (zero_r) begin
      res = 8'd0;
    end else if (sat_r) begin
      res = csr_pkg::LEVEL_TOP;
    end else begin
      res = q_r;
    end
  end

  assign degen = degen_r;

endmodule

### hdl/csr_seq.sv
// Sequencer that steps all three lanes through multiply, sum and divide.
// Depends on csr_pkg for the state and lane control types.
module csr_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_kind,
  input  logic               in_first,
  input  logic               out_free,
  output logic               in_ready,
  output logic               load_out,
  output csr_pkg::lane_ctl_t ctl
);

  csr_pkg::seq_state_t          state_r, state_nxt;
  logic [csr_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                         accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csr_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and step controls
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    in_ready    = 1'b0;
    load_out    = 1'b0;
    ctl         = '0;
    accept      = 1'b0;
    unique case (state_r)
      csr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        if (accept && (in_kind == csr_pkg::KIND_GATHER)) begin
          ctl.gather  = 1'b1;
          ctl.restart = in_first;
        end else if (accept) begin
          ctl.capture = 1'b1;
          state_nxt   = csr_pkg::ST_MUL;
        end
      end
      csr_pkg::ST_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = csr_pkg::ST_SUM;
      end
      csr_pkg::ST_SUM: begin
        ctl.sum   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = csr_pkg::ST_DIV;
      end
      csr_pkg::ST_DIV: begin
        ctl.div = 1'b1;
        if (cnt_r == csr_pkg::CNT_W'(csr_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = csr_pkg::ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      csr_pkg::ST_DONE: begin
        // Hold until the output register can take the result
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = csr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = csr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/contrast_stretch_rgb_top.sv
// Top level of the min/max contrast stretch: config registers, lanes, merge.
// Depends on csr_pkg, csr_stream_if, csr_lane, csr_seq and the macro header.
//
//   channel   direction  handshake         payload
//   in_chan   sink       valid/ready       kind, first_of_frame, red/green/blue_in
//   out_chan  source     valid/ready       red/green/blue_out, degenerate_mask
//   cfg_*     sink       cfg_we only       cfg_index selects out_low/out_high
//
// Gather requests are taken in the idle state and stream one per clock while no
// map request is in flight. A map request passes through multiply, sum, eight
// divider steps and the output load; the input reopens only after the load,
// so map requests never overlap, paced by the restoring divider in each lane.
// Reset is synchronous, active low: statistics go to min 255 / max 0.
// The output register frees the lanes; a stalled result holds the sequencer.
`include "contrast_stretch_rgb_top_macros.svh"

module contrast_stretch_rgb_top (
  input  logic                clk,
  input  logic                rst_n,
  csr_in_if.sink              in_chan,
  csr_out_if.source           out_chan,
  input  logic                cfg_we,
  input  csr_pkg::cfg_reg_t   cfg_index,
  input  logic [7:0]          cfg_wdata
);

  logic [7:0]          out_low_r;
  logic [7:0]          out_high_r;
  logic                out_valid_r;
  csr_pkg::out_pix_t   out_data_r, out_data_nxt;

  csr_pkg::lane_ctl_t  ctl;
  logic                in_ready;
  logic                load_out;
  logic                out_free;
  logic [7:0]          lane_pix [3];
  logic [7:0]          lane_res [3];
  logic [2:0]          lane_degen;

  logic                map_take;
  logic                quiet_gather;
  logic                degen_ok;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_low_r  <= 8'd0;
      out_high_r <= csr_pkg::LEVEL_TOP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csr_pkg::REG_OUT_LOW:  out_low_r  <= cfg_wdata;
        csr_pkg::REG_OUT_HIGH: out_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_chan.ready;

  csr_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_kind  (in_chan.data.kind),
    .in_first (in_chan.data.first_of_frame),
    .out_free (out_free),
    .in_ready (in_ready),
    .load_out (load_out),
    .ctl      (ctl)
  );

  assign in_chan.ready = in_ready;

  assign lane_pix[0] = in_chan.data.red_in;
  assign lane_pix[1] = in_chan.data.green_in;
  assign lane_pix[2] = in_chan.data.blue_in;

  // One lane per colour
  for (genvar c = 0; c < 3; c++) begin : g_lane
    csr_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .pix   (lane_pix[c]),
      .lo    (out_low_r),
      .hi    (out_high_r),
      .res   (lane_res[c]),
      .degen (lane_degen[c])
    );
  end

  // Merge the lane results into one output request
  always_comb begin
    out_data_nxt.red_out         = lane_res[0];
    out_data_nxt.green_out       = lane_res[1];
    out_data_nxt.blue_out        = lane_res[2];
    out_data_nxt.degenerate_mask = lane_degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // Terms watched by the checks below
  assign map_take     = in_chan.valid && in_ready &&
                        (in_chan.data.kind == csr_pkg::KIND_MAP);
  assign quiet_gather = in_chan.valid && in_ready && !out_valid_r &&
                        (in_chan.data.kind == csr_pkg::KIND_GATHER);
  assign degen_ok     = (!out_data_r.degenerate_mask[0] || (out_data_r.red_out == 8'd0)) &&
                        (!out_data_r.degenerate_mask[1] || (out_data_r.green_out == 8'd0)) &&
                        (!out_data_r.degenerate_mask[2] || (out_data_r.blue_out == 8'd0));

  // A map request keeps the input closed on the following cycle
  `CSR_ASSERT_NEXT(a_map_busy, map_take, !in_ready, "input open right after a map request")

  // A gather request never produces a result
  `CSR_ASSERT_NEXT(a_gather_silent, quiet_gather, !out_valid_r, "result raised by a gather")

  // A degenerate channel always reads as zero
  `CSR_ASSERT_NOW(a_degen_zero, out_valid_r, degen_ok, "degenerate channel with non-zero sample")

endmodule

### test/contrast_stretch_rgb_checker.sv
// Checker for the RGB min/max contrast stretch: watches both pixel channels and the
// register port, predicts every stretched pixel and compares it on arrival.
// Depends on csr_pkg and the csr_in_if / csr_out_if interfaces.
`timescale 1ns / 1ps

module contrast_stretch_rgb_checker (
  input  logic              clk,
  input  logic              rst_n,
  csr_in_if                 in_chan,
  csr_out_if                out_chan,
  input  logic              cfg_we,
  input  csr_pkg::cfg_reg_t cfg_index,
  input  logic [7:0]        cfg_wdata,
  output int                mismatches,
  output int                pending
);

  // Target levels and per-channel statistics, as held by the block
  logic [7:0] tgt_low = 8'd0;
  logic [7:0] tgt_high = 8'd255;
  logic [7:0] floor_lvl [3];
  logic [7:0] ceil_lvl [3];

  // Stretched pixels still owed by the block, oldest first
  csr_pkg::out_pix_t stretched_q [$];

  function automatic logic [7:0] channel_sample(csr_pkg::in_pix_t px, int c);
    case (c)
      0: return px.red_in;
      1: return px.green_in;
      default: return px.blue_in;
    endcase
  endfunction

  // Map one pixel through the current statistics and target levels
  function automatic csr_pkg::out_pix_t stretch_pixel(csr_pkg::in_pix_t px);
    csr_pkg::out_pix_t res;
    logic [7:0] lvl [3];
    logic [2:0] flat;
    int lo, hi, mn, mx, smp, num, q;
    lo = tgt_low;
    hi = tgt_high;
    flat = '0;
    for (int c = 0; c < 3; c++) begin
      mn = floor_lvl[c];
      mx = ceil_lvl[c];
      smp = channel_sample(px, c);
      if (mx <= mn) begin
        // flat channel: no usable range
        lvl[c] = 8'd0;
        flat[c] = 1'b1;
      end else begin
        num = (hi - lo) * smp + lo * mx - hi * mn;
        q = num / (mx - mn);
        if (q < 0) q = 0;
        if (q > 255) q = 255;
        lvl[c] = q[7:0];
      end
    end
    res.red_out = lvl[0];
    res.green_out = lvl[1];
    res.blue_out = lvl[2];
    res.degenerate_mask = flat;
    return res;
  endfunction

  always @(posedge clk) begin
    csr_pkg::out_pix_t want;
    csr_pkg::out_pix_t got;
    csr_pkg::in_pix_t px;
    logic [7:0] smp;
    if (!rst_n) begin
      // reset: drop everything owed and restore register defaults
      tgt_low = 8'd0;
      tgt_high = 8'd255;
      for (int c = 0; c < 3; c++) begin
        floor_lvl[c] = 8'd255;
        ceil_lvl[c] = 8'd0;
      end
      stretched_q.delete();
    end else begin
      // compare each delivered result with the oldest one owed
      if (out_chan.valid && out_chan.ready) begin
        got = out_chan.data;
        if (stretched_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result r=%0d g=%0d b=%0d mask=%b", $realtime,
                     got.red_out, got.green_out, got.blue_out, got.degenerate_mask);
          mismatches++;
        end else begin
          want = stretched_q.pop_front();
          if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
              got.blue_out !== want.blue_out ||
              got.degenerate_mask !== want.degenerate_mask) begin
            if (mismatches < 10)
              $display("%0t: mismatch: expected r=%0d g=%0d b=%0d mask=%b, %s",
                       $realtime, want.red_out, want.green_out, want.blue_out,
                       want.degenerate_mask,
                       $sformatf("got r=%0d g=%0d b=%0d mask=%b", got.red_out,
                                 got.green_out, got.blue_out, got.degenerate_mask));
            mismatches++;
          end
        end
      end

      // gather requests update the statistics, map requests owe a result
      if (in_chan.valid && in_chan.ready) begin
        px = in_chan.data;
        if (px.kind == csr_pkg::KIND_MAP) begin
          stretched_q.push_back(stretch_pixel(px));
        end else begin
          for (int c = 0; c < 3; c++) begin
            if (px.first_of_frame) begin
              floor_lvl[c] = 8'd255;
              ceil_lvl[c] = 8'd0;
            end
            smp = channel_sample(px, c);
            if (smp < floor_lvl[c]) floor_lvl[c] = smp;
            if (smp > ceil_lvl[c]) ceil_lvl[c] = smp;
          end
        end
      end

      // register writes
      if (cfg_we) begin
        case (cfg_index)
          csr_pkg::REG_OUT_LOW: tgt_low = cfg_wdata;
          csr_pkg::REG_OUT_HIGH: tgt_high = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = stretched_q.size();
  end

endmodule

### test/contrast_stretch_rgb_top_tb.sv
// Testbench top for contrast_stretch_rgb_top: clock, reset, pixel requests, result
// back-pressure and register writes; the checker module does all the comparing.
// Depends on csr_pkg, the stream interfaces, the block and contrast_stretch_rgb_checker.
`timescale 1ns / 1ps

module contrast_stretch_rgb_top_tb;

  // Cycles to let a map request in flight finish before touching the registers
  localparam int DRAIN_CYCLES = 24;

  logic clk;
  logic rst_n;
  logic cfg_we;
  csr_pkg::cfg_reg_t cfg_index;
  logic [7:0] cfg_wdata;
  int mismatches;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;

  csr_in_if in_chan ();
  csr_out_if out_chan ();

  contrast_stretch_rgb_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  contrast_stretch_rgb_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Present one pixel request, with random idle cycles ahead, and hold until taken
  task automatic send_pixel(input logic kind, input logic fof,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data <= '{kind, fof, r, g, b};
    do @(posedge clk); while (!in_chan.ready);
    sent++;
  endtask

  // Drop valid and wait until every owed result is back and the block is quiet
  task automatic settle();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input csr_pkg::cfg_reg_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_levels(input logic [7:0] lo, input logic [7:0] hi);
    settle();
    write_reg(csr_pkg::REG_OUT_LOW, lo);
    write_reg(csr_pkg::REG_OUT_HIGH, hi);
  endtask

  // One frame: a gather pass then a map pass, with some noise and broken restarts
  task automatic run_frame();
    logic [7:0] lo_c [3];
    logic [7:0] hi_c [3];
    logic [7:0] px [3];
    int a, b, n_gather, n_map;
    bit restart;
    for (int c = 0; c < 3; c++) begin
      a = $urandom_range(255);
      b = $urandom_range(255);
      // now and then a flat channel
      if ($urandom_range(9) == 0) b = a;
      lo_c[c] = (a < b) ? a : b;
      hi_c[c] = (a < b) ? b : a;
    end
    n_gather = $urandom_range(1, 10);
    n_map = $urandom_range(1, 10);
    restart = ($urandom_range(19) != 0);
    for (int i = 0; i < n_gather; i++) begin
      if ($urandom_range(9) == 0) begin
        send_pixel($urandom_range(1), $urandom_range(1), $urandom_range(255),
                   $urandom_range(255), $urandom_range(255));
      end else begin
        for (int c = 0; c < 3; c++) px[c] = $urandom_range(hi_c[c], lo_c[c]);
        send_pixel(csr_pkg::KIND_GATHER, (i == 0) && restart, px[0], px[1], px[2]);
      end
    end
    for (int i = 0; i < n_map; i++) begin
      if ($urandom_range(9) == 0) begin
        send_pixel($urandom_range(1), $urandom_range(1), $urandom_range(255),
                   $urandom_range(255), $urandom_range(255));
      end else begin
        for (int c = 0; c < 3; c++)
          px[c] = ($urandom_range(4) == 0) ? $urandom_range(255)
                                           : $urandom_range(hi_c[c], lo_c[c]);
        send_pixel(csr_pkg::KIND_MAP, $urandom_range(1), px[0], px[1], px[2]);
      end
    end
  endtask

  initial begin
    int target;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = csr_pkg::REG_OUT_LOW;
    cfg_wdata = 8'd0;
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: map before any gather, restart flag on a map request
    send_pixel(csr_pkg::KIND_MAP, 1'b1, 8'd0, 8'd255, 8'd128);
    // one-pixel frame leaves every channel flat
    send_pixel(csr_pkg::KIND_GATHER, 1'b1, 8'd10, 8'd20, 8'd30);
    send_pixel(csr_pkg::KIND_MAP, 1'b0, 8'd10, 8'd20, 8'd30);
    // full range on every channel
    send_pixel(csr_pkg::KIND_GATHER, 1'b1, 8'd0, 8'd255, 8'd0);
    send_pixel(csr_pkg::KIND_GATHER, 1'b0, 8'd255, 8'd0, 8'd255);
    send_pixel(csr_pkg::KIND_MAP, 1'b0, 8'd0, 8'd0, 8'd0);
    send_pixel(csr_pkg::KIND_MAP, 1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(csr_pkg::KIND_MAP, 1'b0, 8'd128, 8'd64, 8'd1);
    // narrow ranges, green flat; samples outside the range saturate
    send_pixel(csr_pkg::KIND_GATHER, 1'b1, 8'd100, 8'd5, 8'd7);
    send_pixel(csr_pkg::KIND_GATHER, 1'b0, 8'd200, 8'd5, 8'd250);
    send_pixel(csr_pkg::KIND_MAP, 1'b0, 8'd0, 8'd5, 8'd255);
    send_pixel(csr_pkg::KIND_MAP, 1'b0, 8'd255, 8'd5, 8'd0);
    send_pixel(csr_pkg::KIND_MAP, 1'b0, 8'd150, 8'd5, 8'd128);
    // keep gathering without a restart
    send_pixel(csr_pkg::KIND_GATHER, 1'b0, 8'd50, 8'd6, 8'd7);
    send_pixel(csr_pkg::KIND_MAP, 1'b0, 8'd50, 8'd6, 8'd7);
    // downward mapping
    set_levels(8'd200, 8'd30);
    send_pixel(csr_pkg::KIND_MAP, 1'b0, 8'd50, 8'd5, 8'd7);
    send_pixel(csr_pkg::KIND_MAP, 1'b0, 8'd200, 8'd6, 8'd250);
    send_pixel(csr_pkg::KIND_MAP, 1'b0, 8'd125, 8'd5, 8'd128);
    // both targets at the top, then fully inverted
    set_levels(8'd255, 8'd255);
    send_pixel(csr_pkg::KIND_MAP, 1'b0, 8'd0, 8'd255, 8'd100);
    set_levels(8'd255, 8'd0);
    send_pixel(csr_pkg::KIND_MAP, 1'b0, 8'd50, 8'd6, 8'd250);
    send_pixel(csr_pkg::KIND_MAP, 1'b0, 8'd200, 8'd0, 8'd7);

    // Random frames across idling phases and target settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      for (int k = 0; k < 3; k++) begin
        case ((ph * 3 + k) % 6)
          0: set_levels(8'd0, 8'd255);
          1: set_levels(8'd255, 8'd0);
          2: set_levels(8'd0, 8'd0);
          3: set_levels(8'd255, 8'd255);
          4: set_levels($urandom_range(255), $urandom_range(255));
          default: set_levels(8'd20, 8'd235);
        endcase
        target = sent + 50;
        while (sent < target) run_frame();
      end
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/csr_pkg.sv
hdl/csr_stream_if.sv
hdl/csr_lane.sv
hdl/csr_seq.sv
hdl/contrast_stretch_rgb_top.sv
test/contrast_stretch_rgb_checker.sv
test/contrast_stretch_rgb_top_tb.sv
